### src/bgc_pkg.sv
// shared types and constants of the button gesture classifier
package bgc_pkg;

  // default sizes
  localparam int unsigned BUTTON_COUNT_DEF = 7;
  localparam int unsigned QUEUE_SLOTS_DEF  = 16;

  // mask fields carry seven buttons, the button vector is at most sixteen wide
  localparam int unsigned MASK_BITS   = 7;
  localparam int unsigned MAX_BUTTONS = 16;

  // queue entry: button in bits 4..2, event type in bits 1..0
  localparam int unsigned EVENT_W = 5;

  // configuration reset values
  localparam logic [15:0] LONG_PRESS_RST    = 16'd1000;
  localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd300;
  localparam logic [6:0]  DOUBLE_MASK_RST   = 7'd0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESSED,
    PH_RELEASED,
    PH_AGAIN
  } phase_e;

  typedef enum logic [1:0] {
    EV_SHORT,
    EV_LONG,
    EV_DOUBLE
  } ev_type_e;

  typedef enum logic [2:0] {
    CMD_EDGE,
    CMD_TICK,
    CMD_POP,
    CMD_PUSH,
    CMD_DRAIN
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_LONG,
    CFG_WINDOW,
    CFG_DMASK
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_TICK,
    S_POP_RD,
    S_POP_DATA,
    S_PUSH,
    S_DRAIN,
    S_RESULT
  } state_e;

endpackage

### src/bgc_ram.sv
// generic single write port ram with registered read
module bgc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/bgc_elapsed.sv
// shared elapsed-time unit: wrapping 32-bit difference compared against a limit
module bgc_elapsed (
  input  logic [31:0] now_i,
  input  logic [31:0] stamp_i,
  input  logic [15:0] limit_i,
  output logic        reached_o
);

  logic [31:0] diff;

  // modulo 2^32 difference, then unsigned compare
  assign diff      = now_i - stamp_i;
  assign reached_o = diff >= {16'd0, limit_i};

endmodule

### src/button_gesture_classifier_top.sv
// Button gesture classifier top level
//
// Input channel (in_valid_i / in_ready_o) takes one command item: a button
// edge, a tick, a pop, a push at the queue front, or a drain. Every item
// gives exactly one result item on out_valid_o / out_ready_i: the popped
// event if any, the queue fill, the mask of buttons waiting for their
// double-click window and a drop flag.
// An edge, push or drain passes through its own state and then S_RESULT; a
// pop reads the ram in S_POP_RD and S_POP_DATA, skipping S_POP_DATA when the
// queue is empty; a tick stays in S_TICK until the last button; an unused
// command goes straight to S_RESULT. A tick walks the buttons one per cycle
// through a single shared subtract-and-compare unit. One item is in flight at
// a time: in_ready_o is high only while idle, and the block goes idle the
// cycle after the result is taken.
// While the receiver stalls the result is held unchanged and no new item is
// taken. The configuration port (cfg_valid_i / cfg_ready_o) is always ready.
// Reset puts every button in idle, empties the queue and loads the default
// configuration; the event store needs no clearing.
module button_gesture_classifier_top
  import bgc_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = BUTTON_COUNT_DEF,
  parameter int unsigned QUEUE_SLOTS  = QUEUE_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [2:0]  button_index_i,
  input  logic        level_pressed_i,
  input  logic [31:0] time_ms_i,
  input  logic [6:0]  held_mask_i,
  input  logic [1:0]  push_type_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        event_valid_o,
  output logic [2:0]  event_button_o,
  output logic [1:0]  event_type_o,
  output logic [3:0]  queue_count_o,
  output logic [6:0]  short_pending_mask_o,
  output logic        dropped_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned BW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int unsigned QW = $clog2(QUEUE_SLOTS);
  localparam int unsigned CW = (QW + 1 > 4) ? QW + 1 : 4;

  state_e state_q, state_d;

  // configuration
  logic [15:0] long_q, win_q;
  logic [6:0]  dmask_q;

  // captured item
  logic [2:0]  btn_q;
  logic        lvl_q;
  logic [31:0] time_q;
  logic [6:0]  held_q;
  logic [1:0]  ptype_q;

  // per-button state
  phase_e      phase_q [BUTTON_COUNT];
  phase_e      phase_d [BUTTON_COUNT];
  logic [31:0] press_q [BUTTON_COUNT];
  logic [31:0] press_d [BUTTON_COUNT];
  logic [31:0] rel_q   [BUTTON_COUNT];
  logic [31:0] rel_d   [BUTTON_COUNT];

  // queue pointers and result registers
  logic [QW-1:0] head_q, head_d, tail_q, tail_d;
  logic [QW-1:0] head_next, head_prev, tail_next;
  logic          drop_q, drop_d;
  logic          ev_valid_q, ev_valid_d;
  logic [2:0]    ev_btn_q, ev_btn_d;
  logic [1:0]    ev_type_q, ev_type_d;

  logic [BW-1:0] tick_idx_q, tick_idx_d;
  logic          tick_last;

  // shared unit and selection
  logic [BW-1:0]          cur_idx;
  phase_e                 cur_phase;
  logic [31:0]            sel_stamp;
  logic [15:0]            sel_limit;
  logic                   reached;
  logic                   btn_ok, ptype_ok;
  logic [MAX_BUTTONS-1:0] dmask_wide, held_wide;
  logic [BUTTON_COUNT-1:0] dbl_vec, held_vec;

  // queue write path
  logic                push_req;
  ev_type_e            push_ev;
  logic                ram_we;
  logic [QW-1:0]       ram_waddr;
  logic [EVENT_W-1:0]  ram_wdata, ram_rdata;

  logic in_acc, out_acc;
  logic [CW-1:0] fill;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q  <= LONG_PRESS_RST;
      win_q   <= DOUBLE_WINDOW_RST;
      dmask_q <= DOUBLE_MASK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LONG:   long_q  <= cfg_data_i;
        CFG_WINDOW: win_q   <= cfg_data_i;
        CFG_DMASK:  dmask_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      btn_q   <= button_index_i;
      lvl_q   <= level_pressed_i;
      time_q  <= time_ms_i;
      held_q  <= held_mask_i;
      ptype_q <= push_type_i;
    end
  end

  // button selection for the shared unit
  assign cur_idx    = (state_q == S_TICK) ? tick_idx_q : BW'(btn_q);
  assign cur_phase  = phase_q[cur_idx];
  assign sel_stamp  = (cur_phase == PH_RELEASED) ? rel_q[cur_idx] : press_q[cur_idx];
  assign sel_limit  = (cur_phase == PH_RELEASED) ? win_q : long_q;
  assign btn_ok     = {2'b00, btn_q} < 5'(BUTTON_COUNT);
  assign ptype_ok   = ptype_q <= 2'(EV_DOUBLE);
  assign dmask_wide = MAX_BUTTONS'(dmask_q);
  assign held_wide  = MAX_BUTTONS'(held_q);
  assign dbl_vec    = dmask_wide[BUTTON_COUNT-1:0];
  assign held_vec   = held_wide[BUTTON_COUNT-1:0];
  assign tick_last  = tick_idx_q == BW'(BUTTON_COUNT - 1);

  bgc_elapsed u_elapsed (
    .now_i    (time_q),
    .stamp_i  (sel_stamp),
    .limit_i  (sel_limit),
    .reached_o(reached)
  );

  // ring pointer neighbours
  assign head_next = (head_q == QW'(QUEUE_SLOTS - 1)) ? '0 : head_q + 1'b1;
  assign head_prev = (head_q == '0) ? QW'(QUEUE_SLOTS - 1) : head_q - 1'b1;
  assign tail_next = (tail_q == QW'(QUEUE_SLOTS - 1)) ? '0 : tail_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(command_i))
            CMD_EDGE:  state_d = S_EDGE;
            CMD_TICK:  state_d = S_TICK;
            CMD_POP:   state_d = S_POP_RD;
            CMD_PUSH:  state_d = S_PUSH;
            CMD_DRAIN: state_d = S_DRAIN;
            default:   state_d = S_RESULT;
          endcase
        end
      end
      S_TICK:     if (tick_last) state_d = S_RESULT;
      S_POP_RD:   state_d = (head_q == tail_q) ? S_RESULT : S_POP_DATA;
      S_EDGE, S_POP_DATA, S_PUSH, S_DRAIN: state_d = S_RESULT;
      S_RESULT:   if (out_ready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE:   in_ready_o  = 1'b1;
      S_RESULT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    phase_d    = phase_q;
    press_d    = press_q;
    rel_d      = rel_q;
    head_d     = head_q;
    tail_d     = tail_q;
    drop_d     = drop_q;
    ev_valid_d = ev_valid_q;
    ev_btn_d   = ev_btn_q;
    ev_type_d  = ev_type_q;
    tick_idx_d = tick_idx_q;
    push_req   = 1'b0;
    push_ev    = EV_SHORT;
    ram_we     = 1'b0;
    ram_waddr  = tail_q;
    ram_wdata  = {3'(cur_idx), EV_SHORT};

    if (in_acc) begin
      drop_d     = 1'b0;
      ev_valid_d = 1'b0;
      ev_btn_d   = '0;
      ev_type_d  = '0;
      tick_idx_d = '0;
    end

    case (state_q)
      // one edge through the per-button phase machine
      S_EDGE: begin
        if (btn_ok) begin
          case (cur_phase)
            PH_IDLE: begin
              if (lvl_q) begin
                phase_d[cur_idx] = PH_PRESSED;
                press_d[cur_idx] = time_q;
              end
            end
            PH_PRESSED: begin
              if (!lvl_q) begin
                if (reached) begin
                  push_req         = 1'b1;
                  push_ev          = EV_LONG;
                  phase_d[cur_idx] = PH_IDLE;
                end else if (dbl_vec[cur_idx]) begin
                  rel_d[cur_idx]   = time_q;
                  phase_d[cur_idx] = PH_RELEASED;
                end else begin
                  push_req         = 1'b1;
                  push_ev          = EV_SHORT;
                  phase_d[cur_idx] = PH_IDLE;
                end
              end
            end
            PH_RELEASED: begin
              if (lvl_q) begin
                if (reached) begin
                  push_req         = 1'b1;
                  push_ev          = EV_SHORT;
                  phase_d[cur_idx] = PH_PRESSED;
                end else begin
                  phase_d[cur_idx] = PH_AGAIN;
                end
                press_d[cur_idx] = time_q;
              end
            end
            default: begin
              if (!lvl_q) begin
                push_req         = 1'b1;
                push_ev          = EV_DOUBLE;
                phase_d[cur_idx] = PH_IDLE;
              end
            end
          endcase
        end
      end
      // one button per cycle, in index order
      S_TICK: begin
        tick_idx_d = tick_idx_q + 1'b1;
        if (cur_phase == PH_PRESSED) begin
          if (held_vec[cur_idx] && reached) begin
            push_req         = 1'b1;
            push_ev          = EV_LONG;
            phase_d[cur_idx] = PH_IDLE;
          end
        end else if (cur_phase == PH_RELEASED) begin
          if (reached) begin
            push_req         = 1'b1;
            push_ev          = EV_SHORT;
            phase_d[cur_idx] = PH_IDLE;
          end
        end
      end
      // head entry is on the ram output
      S_POP_DATA: begin
        ev_valid_d = 1'b1;
        ev_btn_d   = ram_rdata[4:2];
        ev_type_d  = ram_rdata[1:0];
        head_d     = head_next;
      end
      // insert at the front of the queue
      S_PUSH: begin
        if (btn_ok && ptype_ok) begin
          if (head_prev == tail_q) begin
            drop_d = 1'b1;
          end else begin
            head_d    = head_prev;
            ram_we    = 1'b1;
            ram_waddr = head_prev;
            ram_wdata = {btn_q, ptype_q};
          end
        end
      end
      S_DRAIN: begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
          phase_d[i] = PH_IDLE;
          press_d[i] = '0;
          rel_d[i]   = '0;
        end
        head_d = '0;
        tail_d = '0;
      end
      default: ;
    endcase

    // append at the back, dropping when full
    if (push_req) begin
      if (tail_next == head_q) begin
        drop_d = 1'b1;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = tail_q;
        ram_wdata = {3'(cur_idx), push_ev};
        tail_d    = tail_next;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      tick_idx_q <= '0;
      drop_q     <= 1'b0;
      ev_valid_q <= 1'b0;
      ev_btn_q   <= '0;
      ev_type_q  <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        phase_q[i] <= PH_IDLE;
        press_q[i] <= '0;
        rel_q[i]   <= '0;
      end
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      tick_idx_q <= tick_idx_d;
      drop_q     <= drop_d;
      ev_valid_q <= ev_valid_d;
      ev_btn_q   <= ev_btn_d;
      ev_type_q  <= ev_type_d;
      phase_q    <= phase_d;
      press_q    <= press_d;
      rel_q      <= rel_d;
    end
  end

  // event store
  bgc_ram #(
    .WIDTH(EVENT_W),
    .DEPTH(QUEUE_SLOTS)
  ) u_event_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  // queue fill, modulo the ring size
  assign fill = (tail_q >= head_q) ? CW'(tail_q) - CW'(head_q)
                                   : CW'(tail_q) + CW'(QUEUE_SLOTS) - CW'(head_q);

  // buttons waiting for their double-click window
  for (genvar gi = 0; gi < MASK_BITS; gi++) begin : g_pending
    if (gi < BUTTON_COUNT) begin : g_btn
      assign short_pending_mask_o[gi] = phase_q[gi] == PH_RELEASED;
    end else begin : g_none
      assign short_pending_mask_o[gi] = 1'b0;
    end
  end

  assign event_valid_o  = ev_valid_q;
  assign event_button_o = ev_btn_q;
  assign event_type_o   = ev_type_q;
  assign queue_count_o  = fill[3:0];
  assign dropped_o      = drop_q;

endmodule

### src/bgc_checker.sv
// port-level checks of the button gesture classifier, bound to the top level
module bgc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  command_i,
  input logic [2:0]  button_index_i,
  input logic        level_pressed_i,
  input logic [31:0] time_ms_i,
  input logic [6:0]  held_mask_i,
  input logic [1:0]  push_type_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        event_valid_o,
  input logic [2:0]  event_button_o,
  input logic [1:0]  event_type_o,
  input logic [3:0]  queue_count_o,
  input logic [6:0]  short_pending_mask_o,
  input logic        dropped_o
);

  // a waiting input item holds
  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(command_i)
      && $stable(button_index_i) && $stable(level_pressed_i) && $stable(time_ms_i)
      && $stable(held_mask_i) && $stable(push_type_i))
    else $error("input item changed while waiting");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_valid_o)
      && $stable(event_button_o) && $stable(event_type_o)
      && $stable(queue_count_o) && $stable(short_pending_mask_o) && $stable(dropped_o))
    else $error("result changed while stalled");

  // one item in flight: no new item while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("ready while a result is pending");

  // an accepted item closes the input side at once
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an accepted item");

  // without a popped event the event fields read zero
  a_empty_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !event_valid_o |-> event_button_o == 3'd0 && event_type_o == 2'd0)
    else $error("event fields set without an event");

endmodule

bind button_gesture_classifier_top bgc_checker u_bgc_checker (.*);

### tb/gesture_checker.sv
// checker for the button gesture classifier: predicts every result item and compares it
module gesture_checker
  import bgc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  logic [2:0]        command_i,
  input  logic [2:0]        button_index_i,
  input  logic              level_pressed_i,
  input  logic [31:0]       time_ms_i,
  input  logic [6:0]        held_mask_i,
  input  logic [1:0]        push_type_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              event_valid_o,
  input  logic [2:0]        event_button_o,
  input  logic [1:0]        event_type_o,
  input  logic [3:0]        queue_count_o,
  input  logic [6:0]        short_pending_mask_o,
  input  logic              dropped_o,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output int unsigned       fail_count,
  output int unsigned       owed_count
);

  // one result item as the block reports it
  typedef struct packed {
    logic       ev_valid;
    logic [2:0] ev_button;
    logic [1:0] ev_type;
    logic [3:0] fill;
    logic [6:0] pending;
    logic       dropped;
  } gesture_result_t;

  // own copy of the configuration
  logic [15:0] long_ms;
  logic [15:0] window_ms;
  logic [6:0]  dmask;

  // own copy of the button machines and the event ring
  phase_e      btn_phase  [BUTTON_COUNT_DEF];
  logic [31:0] press_ms   [BUTTON_COUNT_DEF];
  logic [31:0] release_ms [BUTTON_COUNT_DEF];
  logic [EVENT_W-1:0] ev_ring [QUEUE_SLOTS_DEF];
  // sixteen slots, so four-bit pointers wrap on their own
  logic [3:0]  ev_head;
  logic [3:0]  ev_tail;
  logic        ev_drop;

  gesture_result_t owed_results [$];
  int unsigned     result_no;

  // event appended at the tail, dropped when the ring is full
  function automatic void push_back_event(input logic [2:0] b, input ev_type_e ty);
    logic [3:0] nxt;
    nxt = ev_tail + 4'd1;
    if (nxt == ev_head) begin
      ev_drop = 1'b1;
    end else begin
      ev_ring[ev_tail] = {b, ty};
      ev_tail = nxt;
    end
  endfunction

  // one edge on a button below the button count
  function automatic void apply_edge(input logic [2:0] b, input logic pressed,
                                     input logic [31:0] t);
    logic [31:0] since;
    case (btn_phase[b])
      PH_IDLE: begin
        if (pressed) begin
          btn_phase[b] = PH_PRESSED;
          press_ms[b] = t;
        end
      end
      PH_PRESSED: begin
        if (!pressed) begin
          since = t - press_ms[b];
          if (since >= long_ms) begin
            push_back_event(b, EV_LONG);
            btn_phase[b] = PH_IDLE;
          end else if (dmask[b]) begin
            release_ms[b] = t;
            btn_phase[b] = PH_RELEASED;
          end else begin
            push_back_event(b, EV_SHORT);
            btn_phase[b] = PH_IDLE;
          end
        end
      end
      PH_RELEASED: begin
        if (pressed) begin
          // a late second press closes the first as short and starts anew
          since = t - release_ms[b];
          if (since >= window_ms) begin
            push_back_event(b, EV_SHORT);
            btn_phase[b] = PH_PRESSED;
          end else begin
            btn_phase[b] = PH_AGAIN;
          end
          press_ms[b] = t;
        end
      end
      default: begin
        if (!pressed) begin
          push_back_event(b, EV_DOUBLE);
          btn_phase[b] = PH_IDLE;
        end
      end
    endcase
  endfunction

  // state update and expected result for one accepted item
  function automatic gesture_result_t classify_gesture(
    input logic [2:0] cmd, input logic [2:0] btn, input logic lvl,
    input logic [31:0] t, input logic [6:0] held, input logic [1:0] ptype);
    gesture_result_t r;
    logic [31:0]     since;
    logic [3:0]      prev;
    logic [EVENT_W-1:0] entry;
    int unsigned     i;
    r = '0;
    ev_drop = 1'b0;
    case (cmd)
      CMD_EDGE: begin
        if (btn < BUTTON_COUNT_DEF) apply_edge(btn, lvl, t);
      end
      CMD_TICK: begin
        // buttons visited in index order, so queue order follows the index
        for (i = 0; i < BUTTON_COUNT_DEF; i++) begin
          if (btn_phase[i] == PH_PRESSED) begin
            since = t - press_ms[i];
            if (held[i] && since >= long_ms) begin
              push_back_event(i[2:0], EV_LONG);
              btn_phase[i] = PH_IDLE;
            end
          end else if (btn_phase[i] == PH_RELEASED) begin
            since = t - release_ms[i];
            if (since >= window_ms) begin
              push_back_event(i[2:0], EV_SHORT);
              btn_phase[i] = PH_IDLE;
            end
          end
        end
      end
      CMD_POP: begin
        if (ev_head != ev_tail) begin
          entry = ev_ring[ev_head];
          r.ev_valid = 1'b1;
          r.ev_button = entry[4:2];
          r.ev_type = entry[1:0];
          ev_head = ev_head + 4'd1;
        end
      end
      CMD_PUSH: begin
        if (btn < BUTTON_COUNT_DEF && ptype <= EV_DOUBLE) begin
          prev = ev_head - 4'd1;
          if (prev == ev_tail) begin
            ev_drop = 1'b1;
          end else begin
            ev_head = prev;
            ev_ring[ev_head] = {btn, ptype};
          end
        end
      end
      CMD_DRAIN: begin
        for (i = 0; i < BUTTON_COUNT_DEF; i++) begin
          btn_phase[i] = PH_IDLE;
          press_ms[i] = '0;
          release_ms[i] = '0;
        end
        ev_head = '0;
        ev_tail = '0;
      end
      default: ;
    endcase
    for (i = 0; i < BUTTON_COUNT_DEF; i++) begin
      r.pending[i] = (btn_phase[i] == PH_RELEASED);
    end
    r.fill = ev_tail - ev_head;
    r.dropped = ev_drop;
    return r;
  endfunction

  // watch the three channels
  always @(posedge clk_i or negedge rst_ni) begin
    gesture_result_t got;
    gesture_result_t want;
    int unsigned     i;
    if (!rst_ni) begin
      long_ms = LONG_PRESS_RST;
      window_ms = DOUBLE_WINDOW_RST;
      dmask = DOUBLE_MASK_RST;
      for (i = 0; i < BUTTON_COUNT_DEF; i++) begin
        btn_phase[i] = PH_IDLE;
        press_ms[i] = '0;
        release_ms[i] = '0;
      end
      ev_head = '0;
      ev_tail = '0;
      owed_results.delete();
      result_no = 0;
      fail_count = 0;
      owed_count = 0;
    end else begin
      // result item first, so an item taken on the same edge queues behind it
      if (out_valid_o && out_ready_i) begin
        got = {event_valid_o, event_button_o, event_type_o, queue_count_o,
               short_pending_mask_o, dropped_o};
        if (owed_results.size() == 0) begin
          if (fail_count < 10)
            $display("gesture_checker: result %0d arrived with nothing expected", result_no);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"gesture_checker: result %0d: exp valid %0b button %0d type %0d",
                        " count %0d pending %b dropped %0b, got valid %0b button %0d",
                        " type %0d count %0d pending %b dropped %0b"},
                       result_no, want.ev_valid, want.ev_button, want.ev_type,
                       want.fill, want.pending, want.dropped, got.ev_valid,
                       got.ev_button, got.ev_type, got.fill, got.pending, got.dropped);
            fail_count++;
          end
        end
        result_no++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LONG:   long_ms = cfg_data_i;
          CFG_WINDOW: window_ms = cfg_data_i;
          CFG_DMASK:  dmask = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        owed_results.push_back(classify_gesture(command_i, button_index_i, level_pressed_i,
                                                time_ms_i, held_mask_i, push_type_i));
      end
      owed_count = owed_results.size();
    end
  end

endmodule

### tb/tb_top.sv
// testbench top for the button gesture classifier: stimulus, flow control and verdict
module tb_top
  import bgc_pkg::*;
();

  // codes the package leaves unnamed
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [2:0] BTN_NONE        = 3'd7;
  localparam logic [1:0] EV_BAD          = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = '0;
  logic [2:0]  button_index_i = '0;
  logic        level_pressed_i = 1'b0;
  logic [31:0] time_ms_i = '0;
  logic [6:0]  held_mask_i = '0;
  logic [1:0]  push_type_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        event_valid_o;
  logic [2:0]  event_button_o;
  logic [1:0]  event_type_o;
  logic [3:0]  queue_count_o;
  logic [6:0]  short_pending_mask_o;
  logic        dropped_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  int unsigned fail_count;
  int unsigned owed_count;

  // stimulus bookkeeping
  logic [31:0] now_ms = '0;
  logic [6:0]  finger_down = '0;
  logic [15:0] long_cfg = LONG_PRESS_RST;
  logic [15:0] window_cfg = DOUBLE_WINDOW_RST;
  int unsigned burst_left = 0;
  bit          gappy = 1'b1;
  logic        hold_req = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  button_gesture_classifier_top i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .command_i, .button_index_i, .level_pressed_i, .time_ms_i, .held_mask_i, .push_type_i,
    .out_valid_o, .out_ready_i,
    .event_valid_o, .event_button_o, .event_type_o, .queue_count_o,
    .short_pending_mask_o, .dropped_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  gesture_checker i_gesture_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .command_i, .button_index_i, .level_pressed_i, .time_ms_i, .held_mask_i, .push_type_i,
    .out_valid_o, .out_ready_i,
    .event_valid_o, .event_button_o, .event_type_o, .queue_count_o,
    .short_pending_mask_o, .dropped_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count, .owed_count
  );

  // offer one item, in bursts with random gaps, and wait until it is taken
  task automatic offer_item(input logic [2:0] cmd, input logic [2:0] btn, input logic lvl,
                            input logic [31:0] t, input logic [6:0] held,
                            input logic [1:0] ptype);
    int unsigned gap;
    logic        took;
    if (burst_left == 0) begin
      gap = gappy ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    button_index_i <= btn;
    level_pressed_i <= lvl;
    time_ms_i <= t;
    held_mask_i <= held;
    push_type_i <= ptype;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  // stop offering and wait for every owed result item
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (owed_count != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    logic took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_timing(input logic [15:0] lp, input logic [15:0] win,
                                input logic [6:0] dm);
    write_reg(CFG_LONG, lp);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_DMASK, {9'd0, dm});
    long_cfg = lp;
    window_cfg = win;
  endtask

  // time step, often landing on or next to a threshold
  function automatic logic [31:0] step_ms();
    logic [31:0] lim;
    lim = $urandom_range(0, 1) ? long_cfg : window_cfg;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, lim);
      6:                return lim - 32'd1;
      7:                return lim;
      8:                return lim + 32'd1;
      9, 10, 11:        return 32'd0;
      12, 13, 14, 15:   return $urandom_range(0, 40);
      16, 17, 18:       return $urandom_range(lim, 2 * lim + 50);
      default:          return $urandom();
    endcase
  endfunction

  // mostly well-formed press and release pairs, with ticks, queue traffic and noise
  task automatic random_item(input bit pop_sparse);
    int unsigned roll;
    logic [2:0]  cmd;
    logic [2:0]  btn;
    logic        lvl;
    logic [31:0] t;
    logic [6:0]  held;
    logic [1:0]  ptype;
    roll = $urandom_range(0, pop_sparse ? 82 : 99);
    cmd = CMD_POP;
    btn = 3'($urandom_range(0, 7));
    lvl = 1'($urandom_range(0, 1));
    t = $urandom();
    held = 7'($urandom_range(0, 127));
    ptype = 2'($urandom_range(0, 3));
    if (roll < 50) begin
      cmd = CMD_EDGE;
      btn = 3'($urandom_range(0, BUTTON_COUNT_DEF - 1));
      lvl = !finger_down[btn];
      finger_down[btn] = lvl;
      now_ms += step_ms();
      t = now_ms;
    end else if (roll < 55) begin
      cmd = CMD_EDGE;
      now_ms += step_ms();
      t = now_ms;
    end else if (roll < 70) begin
      cmd = CMD_TICK;
      now_ms += step_ms();
      t = now_ms;
      if ($urandom_range(0, 3) != 0) held = finger_down;
    end else if (roll < 76) begin
      cmd = CMD_PUSH;
    end else if (roll < 78) begin
      cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    end else if (roll < 79) begin
      cmd = CMD_DRAIN;
      finger_down = '0;
    end
    offer_item(cmd, btn, lvl, t, held, ptype);
  endtask

  // result side: stall patterns of its own, plus one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned beat;
    mode = 0;
    left = 0;
    beat = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        hold_req <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      beat++;
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (beat % 3 == 0);
      endcase
    end
  end

  initial begin
    #1_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, spare commands, ignored edges, short and wrapped long
    offer_item(CMD_POP, 3'd0, 1'b0, 32'd0, 7'd0, EV_SHORT);
    offer_item(CMD_SPARE_FIRST, 3'd0, 1'b0, 32'd0, 7'd0, EV_SHORT);
    offer_item(CMD_SPARE_LAST, 3'd6, 1'b1, 32'hFFFF_FFFF, 7'h7F, EV_BAD);
    offer_item(CMD_EDGE, BTN_NONE, 1'b1, 32'd50, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd0, 1'b0, 32'd60, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd0, 1'b1, 32'd100, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd0, 1'b1, 32'd150, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd0, 1'b0, 32'd1099, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd1, 1'b1, 32'hFFFF_FF00, 7'd0, EV_SHORT);
    offer_item(CMD_TICK, 3'd0, 1'b0, 32'h0000_02E8, 7'h02, EV_SHORT);
    // front pushes, bad operands, pop and drain
    offer_item(CMD_PUSH, 3'd6, 1'b0, 32'd0, 7'd0, EV_DOUBLE);
    offer_item(CMD_PUSH, BTN_NONE, 1'b0, 32'd0, 7'd0, EV_SHORT);
    offer_item(CMD_PUSH, 3'd3, 1'b0, 32'd0, 7'd0, EV_BAD);
    offer_item(CMD_POP, 3'd0, 1'b0, 32'd0, 7'd0, EV_SHORT);
    offer_item(CMD_DRAIN, 3'd0, 1'b0, 32'd0, 7'd0, EV_SHORT);
    settle();

    // directed with double action: double, late second press, window expiry
    program_timing(LONG_PRESS_RST, DOUBLE_WINDOW_RST, 7'h7F);
    offer_item(CMD_EDGE, 3'd3, 1'b1, 32'd10, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd3, 1'b0, 32'd20, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd3, 1'b1, 32'd319, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd3, 1'b0, 32'd330, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd4, 1'b1, 32'd1000, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd4, 1'b0, 32'd1010, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd4, 1'b1, 32'd1310, 7'd0, EV_SHORT);
    offer_item(CMD_EDGE, 3'd4, 1'b0, 32'd1320, 7'd0, EV_SHORT);
    offer_item(CMD_TICK, 3'd0, 1'b0, 32'd1620, 7'd0, EV_SHORT);
    now_ms = 32'd5000;
    finger_down = '0;

    // random phases over several timing settings, extremes among them
    for (phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0:       program_timing(LONG_PRESS_RST, DOUBLE_WINDOW_RST, 7'h7F);
        1:       program_timing(16'd0, 16'd0, 7'($urandom_range(0, 127)));
        2:       program_timing(16'hFFFF, 16'hFFFF, 7'h7F);
        3:       program_timing(16'($urandom_range(20, 300)), 16'($urandom_range(20, 300)),
                                7'($urandom_range(0, 127)));
        4:       program_timing(16'd1, 16'hFFFF, 7'h00);
        default: program_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                7'h7F);
      endcase
      for (n = 0; n < 225; n++) begin
        if (n % 50 == 0) gappy = ($urandom_range(0, 2) != 0);
        // long receiver hold-off while items keep coming
        if (phase == 2 && n == 60) hold_req <= 1'b1;
        random_item(phase == 2 || phase == 5);
      end
    end
    settle();

    if (fail_count == 0 && owed_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
